// ----- hdl/isbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isbf_pkg: shared definitions for the IPv4 source blocklist filter
// Table size, frame offsets, result codes and sequencer types.
// ----------------------------------------------------------------------------
package isbf_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

   localparam logic [5:0] POS_ETH_HI    = 6'd12;
   localparam logic [5:0] POS_ETH_LO    = 6'd13;
   localparam logic [5:0] POS_SRC_FIRST = 6'd26;
   localparam logic [5:0] POS_SRC_LAST  = 6'd29;
   localparam logic [5:0] POS_MAX       = 6'd63;
   // position of the final byte of a minimum-length header
   localparam logic [5:0] POS_ETH_END   = 6'd13;
   localparam logic [5:0] POS_IPV4_END  = 6'd33;

   localparam logic ACT_FRAME  = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_INSERT  = 1'b1;

   localparam logic [1:0] CAUSE_BLOCKED   = 2'd0;
   localparam logic [1:0] CAUSE_ALLOWED   = 2'd1;
   localparam logic [1:0] CAUSE_NOT_IPV4  = 2'd2;
   localparam logic [1:0] CAUSE_TRUNCATED = 2'd3;

   localparam logic [1:0] INS_ADDED   = 2'd0;
   localparam logic [1:0] INS_PRESENT = 2'd1;
   localparam logic [1:0] INS_FULL    = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_HRD,
      S_HINC,
      S_FIN
   } state_type;

   typedef enum logic [2:0] {
      FIN_SHORT,
      FIN_NOTIP,
      FIN_PASS,
      FIN_BLOCK,
      FIN_ADDED,
      FIN_PRESENT,
      FIN_FULL
   } fin_type;

endpackage
`default_nettype wire

// ----- hdl/ipv4_source_blocklist_filter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_source_blocklist_filter_unit: IPv4 source address blocklist filter
// Gathers ethertype and source address from a byte stream, gives one verdict
// per frame and inserts blocked addresses, with per-entry and global counters.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              contents
//  req      in         req_valid / req_stall  action, frame byte, last flag, address
//  rsp      out        rsp_valid / rsp_stall  verdict or insert acknowledgement
//
//  A frame byte other than the last is absorbed in idle, so the next byte may
//  follow at once; the last byte of a short or non-IPv4 frame goes straight
//  to the final step. A lookup or an insert reads one key RAM entry a cycle
//  and stops at a match; a blocked source then passes the hit read and increment steps.
//  Reset clears the valid bits, the counters and the frame state at once.
//  A stalled result holds the sequencer in its final step; new requests are
//  taken in idle while a result waits in the output register.
// ----------------------------------------------------------------------------
module ipv4_source_blocklist_filter_unit
   import isbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [31:0] req_block_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic             rsp_drop_frame,
   output logic [1:0]       rsp_verdict_cause,
   output logic [31:0]      rsp_source_address,
   output logic [63:0]      rsp_entry_hits,
   output logic [63:0]      rsp_passed_total,
   output logic [63:0]      rsp_dropped_total,
   output logic [1:0]       rsp_insert_status
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // control state
   state_type                state_ff, state_in;
   fin_type                  fin_ff, fin_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0]              pass_ff, pass_in;
   logic [63:0]              drop_ff, drop_in;
   logic [5:0]               pos_ff, pos_in;
   logic [15:0]              eth_ff, eth_in;
   logic [31:0]              src_ff, src_in;
   logic                     issue_on_ff, issue_on_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic                     free_found_ff, free_found_in;
   logic                     is_insert_ff, is_insert_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // working payload
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic [31:0]              key_ff, key_in;
   logic [63:0]              hits_ff, hits_in;

   // result payload
   logic        kind_ff, kind_in;
   logic        drop_frame_ff, drop_frame_in;
   logic [1:0]  cause_ff, cause_in;
   logic [31:0] src_out_ff, src_out_in;
   logic [63:0] ehits_ff, ehits_in;
   logic [63:0] ptot_ff, ptot_in;
   logic [63:0] dtot_ff, dtot_in;
   logic [1:0]  status_ff, status_in;

   // RAM ports
   logic              key_wr_en;
   logic [31:0]       key_rd;
   logic              hit_wr_en;
   logic [IDX_W-1:0]  hit_wr_addr;
   logic [63:0]       hit_wr_data;
   logic [63:0]       hit_rd;

   logic accept;
   logic out_free;
   logic match;
   logic free_hit;
   logic [15:0] eth_next;
   logic [31:0] src_next;

   isbf_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd)
   );

   isbf_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_hit_ram (
      .clock   (clock),
      .wr_en   (hit_wr_en),
      .wr_addr (hit_wr_addr),
      .wr_data (hit_wr_data),
      .rd_addr (match_idx_ff),
      .rd_data (hit_rd)
   );

   always_comb begin
      state_in      = state_ff;
      fin_in        = fin_ff;
      valid_in      = valid_ff;
      pass_in       = pass_ff;
      drop_in       = drop_ff;
      pos_in        = pos_ff;
      eth_in        = eth_ff;
      src_in        = src_ff;
      issue_on_in   = issue_on_ff;
      cmp_vld_in    = 1'b0;
      free_found_in = free_found_ff;
      is_insert_in  = is_insert_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_idx_in   = free_idx_ff;
      match_idx_in  = match_idx_ff;
      key_in        = key_ff;
      hits_in       = hits_ff;
      kind_in       = kind_ff;
      drop_frame_in = drop_frame_ff;
      cause_in      = cause_ff;
      src_out_in    = src_out_ff;
      ehits_in      = ehits_ff;
      ptot_in       = ptot_ff;
      dtot_in       = dtot_ff;
      status_in     = status_ff;
      key_wr_en     = 1'b0;
      hit_wr_en     = 1'b0;
      hit_wr_addr   = free_idx_ff;
      hit_wr_data   = '0;

      req_stall = (state_ff != S_IDLE);
      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      match     = cmp_vld_ff && valid_ff[cmp_idx_ff] && (key_rd == key_ff);
      free_hit  = cmp_vld_ff && !valid_ff[cmp_idx_ff];

      rsp_valid_in = rsp_valid_ff && rsp_stall;

      eth_next = eth_ff;
      src_next = src_ff;
      if (pos_ff == POS_ETH_HI || pos_ff == POS_ETH_LO) begin
         eth_next = {eth_ff[7:0], req_data_byte};
      end else if (pos_ff >= POS_SRC_FIRST && pos_ff <= POS_SRC_LAST) begin
         src_next = {src_ff[23:0], req_data_byte};
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_INSERT) begin
                  key_in        = req_block_address;
                  is_insert_in  = 1'b1;
                  scan_idx_in   = '0;
                  issue_on_in   = 1'b1;
                  free_found_in = 1'b0;
                  state_in      = S_SCAN;
               end else if (req_last_byte) begin
                  // end of frame: judge, then drop the gathered header
                  pos_in       = '0;
                  eth_in       = '0;
                  src_in       = '0;
                  key_in       = src_next;
                  is_insert_in = 1'b0;
                  if (pos_ff < POS_ETH_END) begin
                     fin_in   = FIN_SHORT;
                     state_in = S_FIN;
                  end else if (eth_next != ETHERTYPE_IPV4) begin
                     fin_in   = FIN_NOTIP;
                     state_in = S_FIN;
                  end else if (pos_ff < POS_IPV4_END) begin
                     fin_in   = FIN_SHORT;
                     state_in = S_FIN;
                  end else begin
                     scan_idx_in   = '0;
                     issue_on_in   = 1'b1;
                     free_found_in = 1'b0;
                     state_in      = S_SCAN;
                  end
               end else begin
                  eth_in = eth_next;
                  src_in = src_next;
                  if (pos_ff < POS_MAX) begin
                     pos_in = pos_ff + 6'd1;
                  end
               end
            end
         end

         S_SCAN: begin
            // issue one key read a cycle; compare in the cycle after the read
            if (issue_on_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_idx_ff;
               if (scan_idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (free_hit && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (match) begin
               issue_on_in  = 1'b0;
               cmp_vld_in   = 1'b0;
               match_idx_in = cmp_idx_ff;
               if (is_insert_ff) begin
                  fin_in   = FIN_PRESENT;
                  state_in = S_FIN;
               end else begin
                  state_in = S_HRD;
               end
            end else if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
               if (!is_insert_ff) begin
                  fin_in = FIN_PASS;
               end else if (free_found_ff || free_hit) begin
                  fin_in = FIN_ADDED;
               end else begin
                  fin_in = FIN_FULL;
               end
               state_in = S_FIN;
            end
         end

         S_HRD: begin
            state_in = S_HINC;
         end

         S_HINC: begin
            hits_in  = hit_rd + 64'd1;
            fin_in   = FIN_BLOCK;
            state_in = S_FIN;
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = is_insert_ff ? KIND_INSERT : KIND_VERDICT;
               drop_frame_in = 1'b0;
               cause_in      = CAUSE_BLOCKED;
               src_out_in    = key_ff;
               ehits_in      = '0;
               ptot_in       = pass_ff;
               dtot_in       = drop_ff;
               status_in     = INS_ADDED;
               state_in      = S_IDLE;
               case (fin_ff)
                  FIN_SHORT: begin
                     drop_frame_in = 1'b1;
                     cause_in      = CAUSE_TRUNCATED;
                     src_out_in    = '0;
                  end
                  FIN_NOTIP: begin
                     cause_in   = CAUSE_NOT_IPV4;
                     src_out_in = '0;
                  end
                  FIN_PASS: begin
                     cause_in = CAUSE_ALLOWED;
                     pass_in  = pass_ff + 64'd1;
                     ptot_in  = pass_ff + 64'd1;
                  end
                  FIN_BLOCK: begin
                     drop_frame_in = 1'b1;
                     ehits_in      = hits_ff;
                     drop_in       = drop_ff + 64'd1;
                     dtot_in       = drop_ff + 64'd1;
                     hit_wr_en     = 1'b1;
                     hit_wr_addr   = match_idx_ff;
                     hit_wr_data   = hits_ff;
                  end
                  FIN_ADDED: begin
                     key_wr_en             = 1'b1;
                     hit_wr_en             = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                  end
                  FIN_PRESENT: begin
                     status_in = INS_PRESENT;
                  end
                  FIN_FULL: begin
                     status_in = INS_FULL;
                  end
                  default: begin
                     status_in = INS_ADDED;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fin_ff        <= FIN_SHORT;
         valid_ff      <= '0;
         pass_ff       <= '0;
         drop_ff       <= '0;
         pos_ff        <= '0;
         eth_ff        <= '0;
         src_ff        <= '0;
         issue_on_ff   <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         is_insert_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fin_ff        <= fin_in;
         valid_ff      <= valid_in;
         pass_ff       <= pass_in;
         drop_ff       <= drop_in;
         pos_ff        <= pos_in;
         eth_ff        <= eth_in;
         src_ff        <= src_in;
         issue_on_ff   <= issue_on_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_found_ff <= free_found_in;
         is_insert_ff  <= is_insert_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      match_idx_ff  <= match_idx_in;
      key_ff        <= key_in;
      hits_ff       <= hits_in;
      kind_ff       <= kind_in;
      drop_frame_ff <= drop_frame_in;
      cause_ff      <= cause_in;
      src_out_ff    <= src_out_in;
      ehits_ff      <= ehits_in;
      ptot_ff       <= ptot_in;
      dtot_ff       <= dtot_in;
      status_ff     <= status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_drop_frame     = drop_frame_ff;
   assign rsp_verdict_cause  = cause_ff;
   assign rsp_source_address = src_out_ff;
   assign rsp_entry_hits     = ehits_ff;
   assign rsp_passed_total   = ptot_ff;
   assign rsp_dropped_total  = dtot_ff;
   assign rsp_insert_status  = status_ff;

   // compare stage runs only while scanning
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == S_SCAN))
      else $error("compare stage active outside scan");

   // a new result is loaded only by the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result loaded outside final step");

   // an insert claims only an empty entry
   a_add_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && fin_ff == FIN_ADDED && out_free) |-> !valid_ff[free_idx_ff])
      else $error("insert overwrote a valid entry");

   // entries are never removed
   a_valid_keep: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((valid_ff & $past(valid_ff)) == $past(valid_ff)))
      else $error("valid bit cleared");

endmodule
`default_nettype wire

// ----- hdl/isbf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isbf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isbf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
